// ===== sv/assert_macros.svh =====
// Assertion macros shared by the packer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/sbbp_pkg.sv =====
// Types and constants for the seven-bit buffer packer.
package sbbp_pkg;

  localparam int SeptetBits = 7;
  localparam logic [6:0] SeptetMask = 7'h7F;
  localparam logic MoreFlag = 1'b1;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // One accepted byte's worth of output: one or two packed bytes.
  typedef struct packed {
    out_item_t first;
    out_item_t second;
    logic      has_second;
  } work_t;

endpackage

// ===== sv/sbbp_front.sv =====
// Front end: holds the leftover bits and turns each byte into a work entry.
`include "assert_macros.svh"
module sbbp_front import sbbp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     q_valid,
  input  logic     q_ready,
  output work_t    q_item
);

  logic [6:0] leftover_bits, leftover_bits_next;
  logic [2:0] leftover_count, leftover_count_next;

  logic [2:0]  held;
  logic [6:0]  bits;
  logic [3:0]  held1;
  logic [7:0]  top;
  logic [14:0] shl;
  logic [6:0]  kept_bits;
  logic        full;
  logic        at_end;
  logic        take;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign take     = in_valid && q_ready;

  always_comb begin
    // a count of seven or more means an empty leftover
    if (leftover_count >= 3'(SeptetBits)) begin
      held = '0;
      bits = '0;
    end else begin
      held = leftover_count;
      bits = leftover_bits & SeptetMask;
    end
    held1     = {1'b0, held} + 4'd1;
    top       = in_item.data_byte >> held1;
    shl       = {7'd0, in_item.data_byte} << (4'(SeptetBits) - held1);
    kept_bits = shl[6:0];
    full      = (held1 == 4'(SeptetBits));
    at_end    = in_item.end_of_buffer;

    q_item.first.out_byte  = {MoreFlag, bits | top[6:0]};
    q_item.first.out_last  = 1'b0;
    q_item.second.out_byte = {~at_end, kept_bits};
    q_item.second.out_last = at_end;
    q_item.has_second      = full || at_end;

    if (full || at_end) begin
      leftover_bits_next  = '0;
      leftover_count_next = '0;
    end else begin
      leftover_bits_next  = kept_bits;
      leftover_count_next = held1[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits  <= '0;
      leftover_count <= '0;
    end else if (take) begin
      leftover_bits  <= leftover_bits_next;
      leftover_count <= leftover_count_next;
    end
  end

  `ASSERT_CLK(a_count_range, leftover_count <= 3'(SeptetBits - 1),
              "leftover count above six")

endmodule

// ===== sv/sbbp_queue.sv =====
// Short queue of work entries between front and back end.
`include "assert_macros.svh"
module sbbp_queue import sbbp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output work_t pop_item
);

  work_t                entries [QueueDepth];
  logic [QueuePtrW-1:0] wptr;
  logic [QueuePtrW-1:0] rptr;
  logic [QueueCntW-1:0] count;
  logic                 push;
  logic                 pop;

  assign push_ready = (count != QueueCntW'(QueueDepth));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QueuePtrW'(QueueDepth - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QueuePtrW'(QueueDepth - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_item;
    end
  end

  `ASSERT_CLK(a_count_bound, count <= QueueCntW'(QueueDepth), "queue count over depth")

endmodule

// ===== sv/sbbp_back.sv =====
// Back end: plays each work entry out as one or two output items.
`include "assert_macros.svh"
module sbbp_back import sbbp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_ready,
  input  work_t     q_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      out_full;
  out_item_t out_reg;
  logic      pend_valid;
  out_item_t pend;
  logic      can_load;

  assign can_load  = !out_full || out_ready;
  assign q_ready   = can_load && !pend_valid;
  assign out_valid = out_full;
  assign out_item  = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full   <= 1'b0;
      pend_valid <= 1'b0;
    end else if (can_load) begin
      if (pend_valid) begin
        out_full   <= 1'b1;
        pend_valid <= 1'b0;
      end else if (q_valid) begin
        out_full   <= 1'b1;
        pend_valid <= q_item.has_second;
      end else begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      if (pend_valid) begin
        out_reg <= pend;
      end else if (q_valid) begin
        out_reg <= q_item.first;
        pend    <= q_item.second;
      end
    end
  end

  `ASSERT_CLK(a_pend_behind_out, !pend_valid || out_full, "second byte pending with empty output")

endmodule

// ===== sv/seven_bit_buffer_packer.sv =====
// Top level of the seven-bit buffer packer: front end, work queue, back end.
//
// Usage:
//   byte_* channel takes raw bytes (data_byte) with end_of_buffer on the last
//   byte of a buffer. septet_* channel gives packed bytes: septet in bits 6..0,
//   bit 7 set while more bytes of the buffer follow, out_last on the final one.
//   Both channels are valid/ready; an item moves when valid and ready are high.
// Path: an accepted byte is written into a queue entry, and its first packed
//   byte then goes through the back end's output register onto septet_*.
// Throughput: one byte per cycle in and one packed byte per cycle out while
//   septet_ready is high and the queue has room. Every seventh byte of a group
//   and every end-of-buffer byte yields two packed bytes, so the output port
//   sets the rate; the two-entry queue absorbs the pending second bytes.
// Stalls: when the receiver holds septet_ready low the output register and the
//   pending second byte hold, the queue fills, and byte_ready drops once both
//   queue entries are taken. No item is dropped or repeated.
// Reset: synchronous, active high; empties the queue and output register and
//   clears the leftover bits, so the first byte starts a new buffer.
`include "assert_macros.svh"
module seven_bit_buffer_packer import sbbp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_ready,
  input  in_item_t  byte_item,
  output logic      septet_valid,
  input  logic      septet_ready,
  output out_item_t septet_item
);

  // front end to queue
  logic  fq_valid;
  logic  fq_ready;
  work_t fq_item;

  // queue to back end
  logic  qb_valid;
  logic  qb_ready;
  work_t qb_item;

  // Front: classifies each byte (plain, seventh, end of buffer) and builds
  // the packed bytes it produces from the held leftover bits.
  sbbp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_valid),
    .in_ready (byte_ready),
    .in_item  (byte_item),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_item   (fq_item)
  );

  // Queue: lets the front keep taking bytes while the back is busy with a
  // two-byte entry or the receiver stalls.
  sbbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  // Back: output register plus a second-byte holding slot.
  sbbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_item    (qb_item),
    .out_valid (septet_valid),
    .out_ready (septet_ready),
    .out_item  (septet_item)
  );

  // the final byte of a buffer never carries the continuation flag
  `ASSERT_CLK(a_last_no_more,
              !(septet_valid && septet_item.out_last) || !septet_item.out_byte[7],
              "last byte has continuation flag")

endmodule
